// File: design/bfra_pkg.sv
`default_nettype none
package bfra_pkg;

   localparam int unsigned OFF_W = 10;
   localparam int unsigned CNT_W = 11;
   localparam int unsigned PROD_W = 23;
   localparam logic [CNT_W-1:0] HEAP_SIZE = 11'd1024;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   localparam logic CSR_BASE_ADDRESS = 1'b0;
   localparam logic CSR_DESCRIPTOR_SIZE = 1'b1;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NOFIT    = 2'd1,
      ST_FULL     = 2'd2,
      ST_BADCOUNT = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_SCAN,
      S_COMMIT,
      S_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic reject;
      logic step;
      logic commit;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic pre_fail;
      logic scan_last;
      logic out_free;
   } stat_type;

endpackage
`default_nettype wire

// File: design/bfra_ctrl.sv
`default_nettype none
module bfra_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire bfra_pkg::stat_type stat,
   output bfra_pkg::cmd_type       cmd
);

   bfra_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bfra_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bfra_pkg::S_IDLE: begin
            if (req_valid) state_in = bfra_pkg::S_CHECK;
         end
         bfra_pkg::S_CHECK: begin
            state_in = stat.pre_fail ? bfra_pkg::S_DONE : bfra_pkg::S_SCAN;
         end
         bfra_pkg::S_SCAN: begin
            if (stat.scan_last) state_in = bfra_pkg::S_COMMIT;
         end
         bfra_pkg::S_COMMIT: begin
            state_in = bfra_pkg::S_DONE;
         end
         bfra_pkg::S_DONE: begin
            if (stat.out_free) state_in = bfra_pkg::S_IDLE;
         end
         default: begin
            state_in = bfra_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         bfra_pkg::S_IDLE: begin
            req_stall = 1'b0;
            cmd.load = req_valid;
         end
         bfra_pkg::S_CHECK: begin
            cmd.reject = stat.pre_fail;
         end
         bfra_pkg::S_SCAN: begin
            cmd.step = 1'b1;
         end
         bfra_pkg::S_COMMIT: begin
            cmd.commit = 1'b1;
         end
         bfra_pkg::S_DONE: begin
            cmd.finish = stat.out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule
`default_nettype wire

// File: design/bfra_datapath.sv
`default_nettype none
module bfra_datapath #(
   parameter int unsigned MAX_FREE_RANGES = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire bfra_pkg::cmd_type             cmd,
   output bfra_pkg::stat_type                 stat,
   input  wire logic                          req_op,
   input  wire logic [bfra_pkg::CNT_W-1:0]    req_count,
   input  wire logic [bfra_pkg::OFF_W-1:0]    req_release_offset,
   input  wire logic                          csr_write_enable,
   input  wire logic                          csr_index,
   input  wire logic [63:0]                   csr_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [1:0]                         rsp_status,
   output logic [bfra_pkg::OFF_W-1:0]         rsp_offset,
   output logic [63:0]                        rsp_handle,
   output logic [bfra_pkg::CNT_W-1:0]         rsp_free_total
);

   localparam int unsigned IW = $clog2(MAX_FREE_RANGES);
   localparam int unsigned OW = bfra_pkg::OFF_W;
   localparam int unsigned CW = bfra_pkg::CNT_W;
   localparam logic [IW-1:0] LAST_IDX = IW'(MAX_FREE_RANGES - 1);

   // configuration
   logic [63:0] base_ff;
   logic [12:0] dsize_ff;

   // captured request
   logic          op_ff;
   logic [CW-1:0] count_ff;
   logic [OW-1:0] rel_ff;

   // free range table
   logic [MAX_FREE_RANGES-1:0] valid_ff;
   logic [OW-1:0]              first_ff [MAX_FREE_RANGES];
   logic [CW-1:0]              len_ff   [MAX_FREE_RANGES];
   logic [CW-1:0]              free_ff;

   // scan trackers
   logic [IW-1:0] idx_ff;
   logic          best_found_ff, overlap_ff, prev_found_ff, next_found_ff, spare_found_ff;
   logic [IW-1:0] best_idx_ff, prev_idx_ff, next_idx_ff, spare_idx_ff;
   logic [CW-1:0] best_len_ff, next_len_ff;
   logic [OW-1:0] best_first_ff;

   // pending result
   bfra_pkg::status_type          res_status_ff;
   logic [OW-1:0]                 res_offset_ff;
   logic [bfra_pkg::PROD_W-1:0]   res_prod_ff;
   logic                          res_hzero_ff;

   logic                   rsp_valid_ff;
   logic [1:0]             rsp_status_ff;
   logic [OW-1:0]          rsp_offset_ff;
   logic [63:0]            rsp_handle_ff;
   logic [CW-1:0]          rsp_free_ff;

   logic [CW:0]   rel_end;
   logic          ent_v;
   logic [OW-1:0] ent_f;
   logic [CW-1:0] ent_l;
   logic [CW:0]   ent_e;
   logic          pre_fail;
   bfra_pkg::status_type pre_status;

   assign rel_end = {2'b00, rel_ff} + {1'b0, count_ff};
   assign ent_v = valid_ff[idx_ff];
   assign ent_f = first_ff[idx_ff];
   assign ent_l = len_ff[idx_ff];
   assign ent_e = {2'b00, ent_f} + {1'b0, ent_l};

   always_comb begin
      pre_fail = 1'b0;
      pre_status = bfra_pkg::ST_BADCOUNT;
      if (count_ff == '0) begin
         pre_fail = 1'b1;
      end else if (op_ff == bfra_pkg::OP_ALLOC) begin
         if (count_ff > free_ff) begin
            pre_fail = 1'b1;
            pre_status = bfra_pkg::ST_NOFIT;
         end
      end else if (rel_end > {1'b0, bfra_pkg::HEAP_SIZE}) begin
         pre_fail = 1'b1;
      end
   end

   assign stat.pre_fail = pre_fail;
   assign stat.scan_last = (idx_ff == LAST_IDX);
   assign stat.out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
         dsize_ff <= 13'd32;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            bfra_pkg::CSR_BASE_ADDRESS:    base_ff <= csr_data;
            bfra_pkg::CSR_DESCRIPTOR_SIZE: dsize_ff <= csr_data[12:0];
            default: base_ff <= base_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= req_op;
         count_ff <= req_count;
         rel_ff <= req_release_offset;
      end
   end

   // scan: one table entry a cycle
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         idx_ff <= '0;
         best_found_ff <= 1'b0;
         overlap_ff <= 1'b0;
         prev_found_ff <= 1'b0;
         next_found_ff <= 1'b0;
         spare_found_ff <= 1'b0;
      end else if (cmd.step) begin
         idx_ff <= idx_ff + 1'b1;
         if (op_ff == bfra_pkg::OP_ALLOC) begin
            if (ent_v && ent_l >= count_ff &&
                (!best_found_ff || ent_l < best_len_ff ||
                 (ent_l == best_len_ff && ent_f < best_first_ff))) begin
               best_found_ff <= 1'b1;
               best_idx_ff <= idx_ff;
               best_len_ff <= ent_l;
               best_first_ff <= ent_f;
            end
         end else begin
            if (!ent_v) begin
               if (!spare_found_ff) begin
                  spare_found_ff <= 1'b1;
                  spare_idx_ff <= idx_ff;
               end
            end else begin
               if ({2'b00, ent_f} < rel_end && {1'b0, rel_ff} < ent_e[CW-1:0]
                   && ent_e[CW] == 1'b0) begin
                  overlap_ff <= 1'b1;
               end
               if (ent_e == {2'b00, rel_ff}) begin
                  prev_found_ff <= 1'b1;
                  prev_idx_ff <= idx_ff;
               end
               if ({2'b00, ent_f} == rel_end) begin
                  next_found_ff <= 1'b1;
                  next_idx_ff <= idx_ff;
                  next_len_ff <= ent_l;
               end
            end
         end
      end
   end

   // table update and result
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= {{(MAX_FREE_RANGES-1){1'b0}}, 1'b1};
         first_ff[0] <= '0;
         len_ff[0] <= bfra_pkg::HEAP_SIZE;
         free_ff <= bfra_pkg::HEAP_SIZE;
      end else if (cmd.reject) begin
         res_status_ff <= pre_status;
         res_offset_ff <= '0;
         res_prod_ff <= '0;
         res_hzero_ff <= 1'b1;
      end else if (cmd.commit) begin
         res_offset_ff <= '0;
         res_prod_ff <= '0;
         res_hzero_ff <= 1'b1;
         res_status_ff <= bfra_pkg::ST_OK;
         if (op_ff == bfra_pkg::OP_ALLOC) begin
            if (!best_found_ff) begin
               res_status_ff <= bfra_pkg::ST_NOFIT;
            end else begin
               first_ff[best_idx_ff] <= best_first_ff + count_ff[OW-1:0];
               len_ff[best_idx_ff] <= best_len_ff - count_ff;
               valid_ff[best_idx_ff] <= (best_len_ff != count_ff);
               free_ff <= free_ff - count_ff;
               res_offset_ff <= best_first_ff;
               res_prod_ff <= best_first_ff * dsize_ff;
               res_hzero_ff <= 1'b0;
            end
         end else begin
            priority if (overlap_ff) begin
               res_status_ff <= bfra_pkg::ST_BADCOUNT;
            end else if (prev_found_ff && next_found_ff) begin
               len_ff[prev_idx_ff] <= len_ff[prev_idx_ff] + count_ff + next_len_ff;
               valid_ff[next_idx_ff] <= 1'b0;
               free_ff <= free_ff + count_ff;
            end else if (prev_found_ff) begin
               len_ff[prev_idx_ff] <= len_ff[prev_idx_ff] + count_ff;
               free_ff <= free_ff + count_ff;
            end else if (next_found_ff) begin
               first_ff[next_idx_ff] <= rel_ff;
               len_ff[next_idx_ff] <= next_len_ff + count_ff;
               free_ff <= free_ff + count_ff;
            end else if (spare_found_ff) begin
               valid_ff[spare_idx_ff] <= 1'b1;
               first_ff[spare_idx_ff] <= rel_ff;
               len_ff[spare_idx_ff] <= count_ff;
               free_ff <= free_ff + count_ff;
            end else begin
               res_status_ff <= bfra_pkg::ST_FULL;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_status_ff <= res_status_ff;
         rsp_offset_ff <= res_offset_ff;
         rsp_handle_ff <= res_hzero_ff ? 64'd0 : base_ff + 64'(res_prod_ff);
         rsp_free_ff <= free_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_offset = rsp_offset_ff;
   assign rsp_handle = rsp_handle_ff;
   assign rsp_free_total = rsp_free_ff;

   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      free_ff <= bfra_pkg::HEAP_SIZE)
      else $error("free count above heap size");

   a_free_has_range: assert property (@(posedge clock) disable iff (reset)
      (free_ff != '0) |-> (valid_ff != '0))
      else $error("free slots but no valid range");

   a_finish_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result overwritten while held");

   a_finish_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid_ff)
      else $error("finished result not presented");

endmodule
`default_nettype wire

// File: design/best_fit_range_allocator.sv
`default_nettype none
// channel   direction  handshake              payload
// req       in         req_valid / req_stall  req_op, req_count, req_release_offset
// rsp       out        rsp_valid / rsp_stall  rsp_status, rsp_offset, rsp_handle,
//                                             rsp_free_total
// csr       in         csr_write_enable       csr_index, csr_data
//
// one request at a time: after acceptance it passes a count check, a scan of all
// MAX_FREE_RANGES table entries one entry a cycle, a commit and a wait for a free
// result register; a request that the count check rejects skips scan and commit
// reset is synchronous: entry 0 holds the whole heap, all others invalid
// the result register lets the next request be taken while a result waits;
// a second result then waits until the first is taken
module best_fit_range_allocator #(
   parameter int unsigned MAX_FREE_RANGES = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_op,
   input  wire logic [bfra_pkg::CNT_W-1:0]    req_count,
   input  wire logic [bfra_pkg::OFF_W-1:0]    req_release_offset,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [1:0]                         rsp_status,
   output logic [bfra_pkg::OFF_W-1:0]         rsp_offset,
   output logic [63:0]                        rsp_handle,
   output logic [bfra_pkg::CNT_W-1:0]         rsp_free_total,
   input  wire logic                          csr_write_enable,
   input  wire logic                          csr_index,
   input  wire logic [63:0]                   csr_data
);

   // command and status between sequencer and datapath
   bfra_pkg::cmd_type  cmd;
   bfra_pkg::stat_type stat;

   bfra_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // table, scan trackers, handle arithmetic and result register
   bfra_datapath #(
      .MAX_FREE_RANGES (MAX_FREE_RANGES)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_op             (req_op),
      .req_count          (req_count),
      .req_release_offset (req_release_offset),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_offset         (rsp_offset),
      .rsp_handle         (rsp_handle),
      .rsp_free_total     (rsp_free_total)
   );

endmodule
`default_nettype wire
